>>> rtl/rwct_pkg.sv
// rwct_pkg: shared types, codes and defaults for the change tracker.
// No dependencies; every other file uses it by scoped names.
package rwct_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int SEQ_WIDTH   = 32;
   localparam int ST_WIDTH    = 3;
   localparam int CMD_WIDTH   = 4;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CLEAR   = 4'd0,
      CMD_ADD     = 4'd1,
      CMD_QUERY   = 4'd2,
      CMD_ACKB    = 4'd3,
      CMD_REQUEST = 4'd4,
      CMD_SET     = 4'd5,
      CMD_NACK    = 4'd6,
      CMD_ACKNACK = 4'd7,
      CMD_REMOVE  = 4'd8
   } cmd_type;

   typedef enum logic [ST_WIDTH-1:0] {
      ST_UNSENT    = 3'd0,
      ST_UNACKED   = 3'd1,
      ST_REQUESTED = 3'd2,
      ST_ACKED     = 3'd3,
      ST_UNDERWAY  = 3'd4
   } status_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_SET_LOW,
      OP_APPEND,
      OP_OVF,
      OP_ACKED,
      OP_REWIND,
      OP_POP_HEAD,
      OP_POP_TAIL,
      OP_LOW_SM1,
      OP_FIND_STEP,
      OP_ACT,
      OP_CONVERT,
      OP_UN_INIT,
      OP_UN_STEP
   } dp_op_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_HEAD,
      RD_TAIL
   } rd_sel_type;

   typedef struct packed {
      dp_op_type  op;
      rd_sel_type rd_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] cmd;
      logic s_le_low;
      logic count_zero;
      logic full;
      logic idx_done;
      logic rel;
      logic st_acked;
      logic st_bad;
      logic rd_present;
      logic rd_seq_ge_s;
      logic rd_seq_gt_s;
      logic rd_seq_lt_s;
      logic hit;
      logic act_trim;
   } dp_stat_type;

endpackage

>>> rtl/rwct_ifs.sv
// rwct_ifs: request and response channel interfaces (valid/ready).
// Depends on rwct_pkg for default widths.
interface rwct_req_if #(parameter int SEQ_WIDTH = rwct_pkg::SEQ_WIDTH);
   logic                           valid;
   logic                           ready;
   logic [rwct_pkg::CMD_WIDTH-1:0] command;
   logic [SEQ_WIDTH-1:0]           seq_num;
   logic [rwct_pkg::ST_WIDTH-1:0]  status_in;
   logic                           relevant_in;
   modport source (output valid, command, seq_num, status_in, relevant_in, input ready);
   modport sink   (input valid, command, seq_num, status_in, relevant_in, output ready);
endinterface

interface rwct_rsp_if #(parameter int SEQ_WIDTH = rwct_pkg::SEQ_WIDTH);
   logic                 valid;
   logic                 ready;
   logic                 changed;
   logic                 is_acked;
   logic                 table_nonempty;
   logic                 has_unacked;
   logic                 overflow;
   logic                 rewind_flag;
   logic [SEQ_WIDTH-1:0] low_mark_out;
   modport source (output valid, changed, is_acked, table_nonempty, has_unacked, overflow,
                   rewind_flag, low_mark_out, input ready);
   modport sink   (input valid, changed, is_acked, table_nonempty, has_unacked, overflow,
                   rewind_flag, low_mark_out, output ready);
endinterface

>>> rtl/reliable_writer_change_tracker_top.sv
// Delivery-status tracker for one remote reader: holds up to TABLE_DEPTH
// outgoing changes in rising sequence order with a status each, plus the
// acknowledged low mark. One request transfer gives exactly one response
// transfer; the block takes the next request after the response is taken.
// Every command ends with a pass over the held entries to build
// has_unacked; lookups, bulk conversions and trims also walk the entry
// memory (one read port, one write port) entry by entry. The user must
// write reliable_mode through csr_* only while the block is idle; the
// block itself does not enforce it. No clearing pass: the contents of
// unused memory never reach a result.
// Depends on rwct_pkg, rwct_ifs, rwct_ctrl and rwct_datapath.
module reliable_writer_change_tracker_top #(
   parameter int TABLE_DEPTH = rwct_pkg::TABLE_DEPTH,
   parameter int SEQ_WIDTH   = rwct_pkg::SEQ_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   rwct_req_if.sink   req_ch,
   rwct_rsp_if.source rsp_ch,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   // command/status link between sequencer and datapath
   rwct_pkg::ctl_cmd_type ctl;
   rwct_pkg::dp_stat_type stat;

   rwct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // result fields are live registers, stable while the response waits
   rwct_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SEQ_WIDTH   (SEQ_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .command          (req_ch.command),
      .seq_num          (req_ch.seq_num),
      .status_in        (req_ch.status_in),
      .relevant_in      (req_ch.relevant_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .changed          (rsp_ch.changed),
      .is_acked         (rsp_ch.is_acked),
      .table_nonempty   (rsp_ch.table_nonempty),
      .has_unacked      (rsp_ch.has_unacked),
      .overflow         (rsp_ch.overflow),
      .rewind_flag      (rsp_ch.rewind_flag),
      .low_mark_out     (rsp_ch.low_mark_out)
   );

endmodule

>>> rtl/rwct_datapath.sv
// rwct_datapath: entry memory, ring pointers, low mark and result flags.
// Depends on rwct_pkg; driven by rwct_ctrl through ctl_cmd_type.
module rwct_datapath #(
   parameter int TABLE_DEPTH = rwct_pkg::TABLE_DEPTH,
   parameter int SEQ_WIDTH   = rwct_pkg::SEQ_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rwct_pkg::ctl_cmd_type          ctl,
   output rwct_pkg::dp_stat_type          stat,
   input  logic [rwct_pkg::CMD_WIDTH-1:0] command,
   input  logic [SEQ_WIDTH-1:0]           seq_num,
   input  logic [rwct_pkg::ST_WIDTH-1:0]  status_in,
   input  logic                           relevant_in,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   output logic                           changed,
   output logic                           is_acked,
   output logic                           table_nonempty,
   output logic                           has_unacked,
   output logic                           overflow,
   output logic                           rewind_flag,
   output logic [SEQ_WIDTH-1:0]           low_mark_out
);
   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int AW1 = AW + 1;
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int STW = rwct_pkg::ST_WIDTH;
   localparam int WW  = 1 + STW + SEQ_WIDTH;   // {present, status, seq}
   localparam int SW1 = SEQ_WIDTH + 1;

   logic [WW-1:0] mem_ff [TABLE_DEPTH];
   logic [WW-1:0] rd_ff;

   logic [rwct_pkg::CMD_WIDTH-1:0] cmd_ff;
   logic [SEQ_WIDTH-1:0] seq_ff, low_ff, low_in;
   logic [STW-1:0]       st_ff, kst_ff, kst_in;
   logic                 rel_ff, mode_ff;
   logic [AW-1:0]        head_ff, head_in, kslot_ff, kslot_in;
   logic [CW-1:0]        count_ff, count_in, idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic changed_ff, changed_in, acked_ff, acked_in, ovf_ff, ovf_in;
   logic rewind_ff, rewind_in, unacked_ff, unacked_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr, tail, idx_slot;
   logic [WW-1:0]        wr_data;
   logic                 rd_present, hit, s_eq_low1, ss_remove, cv_match;
   logic [STW-1:0]       rd_status, eff_st, cv_from, cv_to;
   logic [SEQ_WIDTH-1:0] rd_seq;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] i);
      logic [AW:0] sum;
      sum = {1'b0, h} + AW1'(i);
      if (sum >= AW1'(TABLE_DEPTH)) begin
         sum = sum - AW1'(TABLE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign rd_present = rd_ff[WW-1];
   assign rd_status  = rd_ff[WW-2 -: STW];
   assign rd_seq     = rd_ff[SEQ_WIDTH-1:0];
   assign hit        = rd_present && (rd_seq == seq_ff);
   assign tail       = slot_of(head_ff, count_ff - CW'(1));
   assign idx_slot   = slot_of(head_ff, idx_ff);

   // best-effort readers take underway as acknowledged
   assign eff_st = (st_ff == rwct_pkg::ST_UNDERWAY && !mode_ff) ? rwct_pkg::ST_ACKED : st_ff;
   assign s_eq_low1 = ({1'b0, seq_ff} == ({1'b0, low_ff} + SW1'(1)));
   assign ss_remove = found_ff && eff_st == rwct_pkg::ST_ACKED && s_eq_low1;
   assign cv_from = (cmd_ff == rwct_pkg::CMD_NACK) ? rwct_pkg::ST_UNDERWAY
                                                   : rwct_pkg::ST_REQUESTED;
   assign cv_to   = (cmd_ff == rwct_pkg::CMD_NACK) ? rwct_pkg::ST_UNACKED
                                                   : rwct_pkg::ST_UNSENT;
   assign cv_match = rd_present && rd_status == cv_from;

   always_comb begin
      case (ctl.rd_sel)
         rwct_pkg::RD_IDX:  rd_addr = idx_slot;
         rwct_pkg::RD_TAIL: rd_addr = tail;
         default:           rd_addr = head_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = kslot_ff;
      wr_data = {1'b1, kst_ff, seq_ff};
      case (ctl.op)
         rwct_pkg::OP_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, count_ff);
            wr_data = {1'b1, st_ff, seq_ff};
         end
         rwct_pkg::OP_CONVERT: begin
            wr_en   = cv_match;
            wr_addr = idx_slot;
            wr_data = {1'b1, cv_to, rd_seq};
         end
         rwct_pkg::OP_ACT: begin
            case (cmd_ff)
               rwct_pkg::CMD_REQUEST: begin
                  wr_en   = found_ff && kst_ff == rwct_pkg::ST_UNACKED;
                  wr_data = {1'b1, rwct_pkg::ST_REQUESTED, seq_ff};
               end
               rwct_pkg::CMD_SET: begin
                  if (ss_remove) begin
                     wr_en   = 1'b1;
                     wr_data = {1'b0, kst_ff, seq_ff};
                  end else begin
                     wr_en   = found_ff && kst_ff != eff_st;
                     wr_data = {1'b1, eff_st, seq_ff};
                  end
               end
               rwct_pkg::CMD_REMOVE: begin
                  wr_en   = found_ff;
                  wr_data = {1'b0, kst_ff, seq_ff};
               end
               default: wr_en = 1'b0;
            endcase
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      low_in     = low_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      kslot_in   = kslot_ff;
      kst_in     = kst_ff;
      changed_in = changed_ff;
      acked_in   = acked_ff;
      ovf_in     = ovf_ff;
      rewind_in  = rewind_ff;
      unacked_in = unacked_ff;
      case (ctl.op)
         rwct_pkg::OP_LOAD: begin
            idx_in     = '0;
            found_in   = 1'b0;
            changed_in = 1'b0;
            acked_in   = 1'b0;
            ovf_in     = 1'b0;
            rewind_in  = 1'b0;
         end
         rwct_pkg::OP_CLEAR: begin
            head_in    = '0;
            count_in   = '0;
            low_in     = '0;
            changed_in = 1'b1;
         end
         rwct_pkg::OP_SET_LOW: begin
            low_in     = seq_ff;
            changed_in = 1'b1;
         end
         rwct_pkg::OP_APPEND: begin
            count_in   = count_ff + CW'(1);
            changed_in = 1'b1;
         end
         rwct_pkg::OP_OVF:    ovf_in    = 1'b1;
         rwct_pkg::OP_ACKED:  acked_in  = 1'b1;
         rwct_pkg::OP_REWIND: rewind_in = 1'b1;
         rwct_pkg::OP_POP_HEAD: begin
            head_in    = (head_ff == AW'(TABLE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in   = count_ff - CW'(1);
            changed_in = 1'b1;
         end
         rwct_pkg::OP_POP_TAIL: count_in = count_ff - CW'(1);
         rwct_pkg::OP_LOW_SM1: begin
            if (low_ff != seq_ff - SEQ_WIDTH'(1)) begin
               low_in     = seq_ff - SEQ_WIDTH'(1);
               changed_in = 1'b1;
            end
         end
         rwct_pkg::OP_FIND_STEP: begin
            if (hit) begin
               found_in = 1'b1;
               kslot_in = idx_slot;
               kst_in   = rd_status;
            end
            idx_in = idx_ff + CW'(1);
         end
         rwct_pkg::OP_ACT: begin
            case (cmd_ff)
               rwct_pkg::CMD_QUERY: acked_in = !found_ff || kst_ff == rwct_pkg::ST_ACKED;
               rwct_pkg::CMD_REQUEST: begin
                  if (found_ff && kst_ff == rwct_pkg::ST_UNACKED) begin
                     changed_in = 1'b1;
                  end
               end
               rwct_pkg::CMD_SET: begin
                  if (eff_st == rwct_pkg::ST_ACKED && s_eq_low1) begin
                     low_in     = seq_ff;
                     changed_in = 1'b1;
                  end
                  if (!ss_remove && found_ff && kst_ff != eff_st) begin
                     changed_in = 1'b1;
                  end
               end
               rwct_pkg::CMD_REMOVE: begin
                  if (found_ff) begin
                     changed_in = 1'b1;
                  end
               end
               default: changed_in = changed_ff;
            endcase
         end
         rwct_pkg::OP_CONVERT: begin
            if (cv_match) begin
               changed_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         rwct_pkg::OP_UN_INIT: begin
            idx_in     = '0;
            unacked_in = 1'b0;
         end
         rwct_pkg::OP_UN_STEP: begin
            if (rd_present && rd_status == rwct_pkg::ST_UNACKED) begin
               unacked_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         low_ff     <= '0;
         mode_ff    <= 1'b0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         changed_ff <= 1'b0;
         acked_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
         rewind_ff  <= 1'b0;
         unacked_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         low_ff     <= low_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
         changed_ff <= changed_in;
         acked_ff   <= acked_in;
         ovf_ff     <= ovf_in;
         rewind_ff  <= rewind_in;
         unacked_ff <= unacked_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kslot_ff <= kslot_in;
      kst_ff   <= kst_in;
      if (ctl.op == rwct_pkg::OP_LOAD) begin
         cmd_ff <= command;
         seq_ff <= seq_num;
         st_ff  <= status_in;
         rel_ff <= relevant_in;
      end
   end

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.s_le_low    = seq_ff <= low_ff;
      stat.count_zero  = count_ff == '0;
      stat.full        = count_ff >= CW'(TABLE_DEPTH);
      stat.idx_done    = idx_ff == count_ff;
      stat.rel         = rel_ff;
      stat.st_acked    = st_ff == rwct_pkg::ST_ACKED;
      stat.st_bad      = st_ff > rwct_pkg::ST_UNDERWAY;
      stat.rd_present  = rd_present;
      stat.rd_seq_ge_s = rd_seq >= seq_ff;
      stat.rd_seq_gt_s = rd_seq > seq_ff;
      stat.rd_seq_lt_s = rd_seq < seq_ff;
      stat.hit         = hit;
      stat.act_trim    = (cmd_ff == rwct_pkg::CMD_SET && ss_remove) ||
                         (cmd_ff == rwct_pkg::CMD_REMOVE && found_ff);
   end

   assign changed        = changed_ff;
   assign is_acked       = acked_ff;
   assign table_nonempty = count_ff != '0;
   assign has_unacked    = unacked_ff;
   assign overflow       = ovf_ff;
   assign rewind_flag    = rewind_ff;
   assign low_mark_out   = low_ff;

endmodule

>>> rtl/rwct_ctrl.sv
// rwct_ctrl: command sequencer; walks the table through the datapath.
// Depends on rwct_pkg; talks to rwct_datapath by ctl/stat structs only.
module rwct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rwct_pkg::dp_stat_type stat,
   output rwct_pkg::ctl_cmd_type ctl
);
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_ADD_RD, S_ADD_CHK, S_AB_RD, S_AB_CHK, S_AB_END,
      S_RM_RD, S_RM_CHK, S_FD_RD, S_FD_CHK, S_ACT, S_CV_RD, S_CV_CHK,
      S_TF_RD, S_TF_CHK, S_TB_RD, S_TB_CHK, S_UN_INIT, S_UN_RD, S_UN_CHK, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl.op     = rwct_pkg::OP_NONE;
      ctl.rd_sel = rwct_pkg::RD_HEAD;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op   = rwct_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_UN_INIT;
            case (stat.cmd)
               rwct_pkg::CMD_CLEAR: ctl.op = rwct_pkg::OP_CLEAR;
               rwct_pkg::CMD_ADD: begin
                  if (!stat.s_le_low) begin
                     if (stat.count_zero) begin
                        if (stat.st_acked) begin
                           ctl.op = rwct_pkg::OP_SET_LOW;
                        end else if (stat.rel) begin
                           ctl.op = rwct_pkg::OP_APPEND;
                        end
                     end else begin
                        state_in = S_ADD_RD;
                     end
                  end
               end
               rwct_pkg::CMD_QUERY: begin
                  if (stat.s_le_low || stat.count_zero) begin
                     ctl.op = rwct_pkg::OP_ACKED;
                  end else begin
                     state_in = S_FD_RD;
                  end
               end
               rwct_pkg::CMD_ACKB: begin
                  if (stat.s_le_low) begin
                     ctl.op = rwct_pkg::OP_REWIND;
                  end else begin
                     state_in = S_AB_RD;
                  end
               end
               rwct_pkg::CMD_REQUEST: state_in = S_FD_RD;
               rwct_pkg::CMD_SET: begin
                  if (!stat.st_bad && !stat.s_le_low) begin
                     state_in = S_FD_RD;
                  end
               end
               rwct_pkg::CMD_NACK, rwct_pkg::CMD_ACKNACK: state_in = S_CV_RD;
               rwct_pkg::CMD_REMOVE: begin
                  if (!stat.count_zero) begin
                     state_in = S_RM_RD;
                  end
               end
               default: state_in = S_UN_INIT;
            endcase
         end
         S_ADD_RD: begin
            ctl.rd_sel = rwct_pkg::RD_TAIL;
            state_in   = S_ADD_CHK;
         end
         S_ADD_CHK: begin
            if (!stat.rd_seq_ge_s && stat.rel) begin
               ctl.op = stat.full ? rwct_pkg::OP_OVF : rwct_pkg::OP_APPEND;
            end
            state_in = S_UN_INIT;
         end
         S_AB_RD: state_in = stat.count_zero ? S_AB_END : S_AB_CHK;
         S_AB_CHK: begin
            if (!stat.rd_present || stat.rd_seq_lt_s) begin
               ctl.op   = rwct_pkg::OP_POP_HEAD;
               state_in = S_AB_RD;
            end else begin
               state_in = S_AB_END;
            end
         end
         S_AB_END: begin
            ctl.op   = rwct_pkg::OP_LOW_SM1;
            state_in = S_UN_INIT;
         end
         S_RM_RD: state_in = S_RM_CHK;
         S_RM_CHK: state_in = stat.rd_seq_gt_s ? S_UN_INIT : S_FD_RD;
         S_FD_RD: begin
            ctl.rd_sel = rwct_pkg::RD_IDX;
            state_in   = stat.idx_done ? S_ACT : S_FD_CHK;
         end
         S_FD_CHK: begin
            ctl.op   = rwct_pkg::OP_FIND_STEP;
            state_in = stat.hit ? S_ACT : S_FD_RD;
         end
         S_ACT: begin
            ctl.op   = rwct_pkg::OP_ACT;
            state_in = stat.act_trim ? S_TF_RD : S_UN_INIT;
         end
         S_CV_RD: begin
            ctl.rd_sel = rwct_pkg::RD_IDX;
            state_in   = stat.idx_done ? S_UN_INIT : S_CV_CHK;
         end
         S_CV_CHK: begin
            ctl.op   = rwct_pkg::OP_CONVERT;
            state_in = S_CV_RD;
         end
         S_TF_RD: state_in = stat.count_zero ? S_TB_RD : S_TF_CHK;
         S_TF_CHK: begin
            if (!stat.rd_present) begin
               ctl.op   = rwct_pkg::OP_POP_HEAD;
               state_in = S_TF_RD;
            end else begin
               state_in = S_TB_RD;
            end
         end
         S_TB_RD: begin
            ctl.rd_sel = rwct_pkg::RD_TAIL;
            state_in   = stat.count_zero ? S_UN_INIT : S_TB_CHK;
         end
         S_TB_CHK: begin
            if (!stat.rd_present) begin
               ctl.op   = rwct_pkg::OP_POP_TAIL;
               state_in = S_TB_RD;
            end else begin
               state_in = S_UN_INIT;
            end
         end
         S_UN_INIT: begin
            ctl.op   = rwct_pkg::OP_UN_INIT;
            state_in = S_UN_RD;
         end
         S_UN_RD: begin
            ctl.rd_sel = rwct_pkg::RD_IDX;
            state_in   = stat.idx_done ? S_RESP : S_UN_CHK;
         end
         S_UN_CHK: begin
            ctl.op   = rwct_pkg::OP_UN_STEP;
            state_in = S_UN_RD;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

endmodule
